### rtl/core/twstat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twstat_pkg
// Shared types and constants of the time window statistics block.
// ----------------------------------------------------------------------------
package twstat_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int RESULT_W    = 33;
    localparam int COUNT_OUT_W = 9;
    localparam int MODE_W      = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_DATA_W    = 64;
    localparam int M_DATA_W    = 48;

    localparam logic [MODE_W-1:0] MODE_LAST      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAX       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ABS_MAX   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ABS_MIN   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_AMPLITUDE = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE     = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_STAT_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRUNE_RD,
        ST_PRUNE_CHK,
        ST_SCAN,
        ST_FINISH,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic en;
        logic first;
    } acc_ctl_t;

endpackage

### rtl/core/time_window_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_statistics_top
// Sliding time window statistics over timestamped Q16.16 samples.
// In last value mode the result comes straight from the accepted beat; otherwise
// expired entries are dropped first, the spare mode then returns the new value,
// the other modes scan the samples left, and the mean also runs the divider.
// One beat at a time: s_tready stays low until the result is registered; the
// history is walked one entry per cycle and the divider yields one bit per cycle.
// Reset clears control state and configuration; datapath registers and history contents are not cleared.
// ----------------------------------------------------------------------------
module time_window_statistics_top #(
    parameter int HISTORY_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_time, sample_value
    input  logic [twstat_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_value, window_count, dropped_oldest, zero fill
    output logic [twstat_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [twstat_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [twstat_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import twstat_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = SAMPLE_W + $clog2(HISTORY_DEPTH);
    localparam int PAD_W = M_DATA_W - RESULT_W - COUNT_OUT_W - 1;

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(HISTORY_DEPTH))
        begin
            s = s - (CW+1)'(HISTORY_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [MODE_W-1:0]   stat_mode_reg;
    logic [SAMPLE_W-1:0] window_reg;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [AW-1:0]       oldest_reg, oldest_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic                first_reg, first_next;
    logic                drop_reg, drop_next;
    logic [SAMPLE_W-1:0] now_reg, now_next;
    logic [SAMPLE_W-1:0] value_reg, value_next;
    logic [RESULT_W-1:0] res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [SAMPLE_W-1:0] rd_time;
    logic [SAMPLE_W-1:0] rd_value;
    logic [SAMPLE_W-1:0] age;
    logic                full;
    logic                in_beat;

    acc_ctl_t                   acc_ctl;
    logic signed [SW-1:0]       acc_sum;
    logic signed [SAMPLE_W-1:0] acc_max;
    logic signed [SAMPLE_W-1:0] acc_min;
    logic [SAMPLE_W-1:0]        acc_amax;
    logic [SAMPLE_W-1:0]        acc_amin;
    logic signed [RESULT_W:0]   span;

    logic                 div_start;
    logic                 div_done;
    logic signed [SW-1:0] div_quo;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign full     = (count_reg >= CW'(HISTORY_DEPTH));
    assign age      = (now_reg >= rd_time) ? (now_reg - rd_time) : '0;
    assign span     = (RESULT_W+1)'(acc_max) - (RESULT_W+1)'(acc_min);
    assign wr_addr  = full ? oldest_reg : slot_add(oldest_reg, count_reg);
    assign wr_en    = in_beat && (stat_mode_reg != MODE_LAST);
    assign rd_addr  = (state_reg == ST_SCAN) ? rd_ptr_reg : oldest_reg;

    twstat_hist #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_time  (s_tdata[SAMPLE_W-1:0]),
        .wr_value (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .rd_addr  (rd_addr),
        .rd_time  (rd_time),
        .rd_value (rd_value)
    );

    twstat_acc #(
        .SW (SW)
    ) u_acc (
        .clk     (clk),
        .ctl     (acc_ctl),
        .value   ($signed(rd_value)),
        .sum     (acc_sum),
        .max_val (acc_max),
        .min_val (acc_min),
        .abs_max (acc_amax),
        .abs_min (acc_amin)
    );

    twstat_div #(
        .NW (SW),
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_sum),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_mode_reg <= MODE_LAST;
            window_reg    <= SAMPLE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_STAT_MODE:     stat_mode_reg <= cfg_wdata[MODE_W-1:0];
                CFG_WINDOW_LENGTH: window_reg    <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        rd_ptr_reg   <= rd_ptr_next;
        drop_reg     <= drop_next;
        now_reg      <= now_next;
        value_reg    <= value_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        drop_next      = drop_reg;
        now_next       = now_reg;
        value_next     = value_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        acc_ctl.en     = 1'b0;
        acc_ctl.first  = first_reg;
        div_start      = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    mode_next  = stat_mode_reg;
                    now_next   = s_tdata[SAMPLE_W-1:0];
                    value_next = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    if (stat_mode_reg == MODE_LAST)
                    begin
                        oldest_next = '0;
                        count_next  = '0;
                        drop_next   = 1'b0;
                        res_next    = RESULT_W'($signed(s_tdata[2*SAMPLE_W-1:SAMPLE_W]));
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        if (full)
                        begin
                            oldest_next = slot_add(oldest_reg, CW'(1));
                            count_next  = CW'(HISTORY_DEPTH);
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        drop_next  = full;
                        state_next = ST_PRUNE_RD;
                    end
                end
            end

            ST_PRUNE_RD:
            begin
                state_next = ST_PRUNE_CHK;
            end

            ST_PRUNE_CHK:
            begin
                if (age > window_reg)
                begin
                    oldest_next = slot_add(oldest_reg, CW'(1));
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_PRUNE_RD;
                end
                else if (mode_reg == MODE_SPARE)
                begin
                    res_next   = RESULT_W'($signed(value_reg));
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_ptr_next = oldest_reg;
                    issue_next  = '0;
                    pend_next   = 1'b0;
                    first_next  = 1'b1;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                acc_ctl.en = pend_reg;
                if (pend_reg)
                begin
                    first_next = 1'b0;
                end
                if (issue_reg < count_reg)
                begin
                    rd_ptr_next = slot_add(rd_ptr_reg, CW'(1));
                    issue_next  = issue_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                state_next = ST_DONE;
                case (mode_reg)
                    MODE_MEAN:
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    MODE_MAX:       res_next = RESULT_W'(acc_max);
                    MODE_MIN:       res_next = RESULT_W'(acc_min);
                    MODE_ABS_MAX:   res_next = {1'b0, acc_amax};
                    MODE_ABS_MIN:   res_next = {1'b0, acc_amin};
                    MODE_AMPLITUDE: res_next = span[RESULT_W-1:0];
                    default:        res_next = RESULT_W'($signed(value_reg));
                endcase
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quo[RESULT_W-1:0];
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_LAST)
                    begin
                        out_data_next = {PAD_W'(0), 1'b0, COUNT_OUT_W'(1), res_reg};
                    end
                    else
                    begin
                        out_data_next = {PAD_W'(0), drop_reg, COUNT_OUT_W'(count_reg),
                                         res_reg};
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/core/twstat_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twstat_hist
// Sample history memory: timestamps and values, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module twstat_hist #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [twstat_pkg::SAMPLE_W-1:0]   wr_time,
    input  logic [twstat_pkg::SAMPLE_W-1:0]   wr_value,
    input  logic [AW-1:0]                     rd_addr,
    output logic [twstat_pkg::SAMPLE_W-1:0]   rd_time,
    output logic [twstat_pkg::SAMPLE_W-1:0]   rd_value
);
    import twstat_pkg::*;

    logic [SAMPLE_W-1:0] time_mem  [DEPTH];
    logic [SAMPLE_W-1:0] value_mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_time_reg;
    logic [SAMPLE_W-1:0] rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr]  <= wr_time;
            value_mem[wr_addr] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_time_reg  <= time_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    assign rd_time  = rd_time_reg;
    assign rd_value = rd_value_reg;

endmodule

### rtl/core/twstat_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twstat_acc
// Shared accumulate and compare unit: running sum, min, max and the
// min and max of magnitudes, one sample per beat.
// ----------------------------------------------------------------------------
module twstat_acc #(
    parameter int SW = 40
) (
    input  logic                                   clk,
    input  twstat_pkg::acc_ctl_t                   ctl,
    input  logic signed [twstat_pkg::SAMPLE_W-1:0] value,
    output logic signed [SW-1:0]                   sum,
    output logic signed [twstat_pkg::SAMPLE_W-1:0] max_val,
    output logic signed [twstat_pkg::SAMPLE_W-1:0] min_val,
    output logic [twstat_pkg::SAMPLE_W-1:0]        abs_max,
    output logic [twstat_pkg::SAMPLE_W-1:0]        abs_min
);
    import twstat_pkg::*;

    logic signed [SW-1:0]       sum_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0]        amax_reg;
    logic [SAMPLE_W-1:0]        amin_reg;
    logic [SAMPLE_W-1:0]        mag;

    assign mag = value[SAMPLE_W-1] ? (~value + 1'b1) : value;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.first)
            begin
                sum_reg  <= SW'(value);
                max_reg  <= value;
                min_reg  <= value;
                amax_reg <= mag;
                amin_reg <= mag;
            end
            else
            begin
                sum_reg <= sum_reg + SW'(value);
                if (value > max_reg)
                begin
                    max_reg <= value;
                end
                if (value < min_reg)
                begin
                    min_reg <= value;
                end
                if (mag > amax_reg)
                begin
                    amax_reg <= mag;
                end
                if (mag < amin_reg)
                begin
                    amin_reg <= mag;
                end
            end
        end
    end

    assign sum     = sum_reg;
    assign max_val = max_reg;
    assign min_val = min_reg;
    assign abs_max = amax_reg;
    assign abs_min = amin_reg;

endmodule

### rtl/core/twstat_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twstat_div
// Bit-serial restoring divider: signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twstat_div #(
    parameter int NW = 40,
    parameter int DW = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic [DW-1:0]        divisor,
    output logic                 done,
    output logic signed [NW-1:0] quotient
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DW:0]      rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    div_reg;
    logic             neg_reg;
    logic [DW:0]      rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign fits   = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(NW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[NW-1] ? (~dividend + 1'b1) : dividend;
            div_reg <= divisor;
            neg_reg <= dividend[NW-1];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule
